### sv/dtef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtef_pkg
// Shared types and constants for the depth temporal EMA filter.
// ----------------------------------------------------------------------------
package dtef_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam int DEPTH_W = 16;
    localparam int FILT_W  = 24;
    localparam int WT_W    = 9;
    localparam int DIM_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [WT_W-1:0] WT_FULL = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    // One accepted pixel on its way from the sequencer to the blend stage.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [DEPTH_W-1:0] depth;
        logic               blend;
        logic               eof;
    } t_item;

endpackage

### sv/dtef_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtef_ctrl
// Configuration registers, raster position counters and history tracking.
// ----------------------------------------------------------------------------
module dtef_ctrl
    import dtef_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [DEPTH_W-1:0]    i_depth_mm,
    output t_item                 o_item,
    output logic [WT_W-1:0]       o_weight
);

    logic              r_enable;
    logic [WT_W-1:0]   r_weight;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic              r_hist;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_addr;

    logic              n_hist;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [ADDR_W-1:0] n_addr;

    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_last;
    logic              eol;
    logic              eof;

    // A zero size acts as one; sizes above the store geometry saturate.
    always_comb begin
        if (r_width == '0) begin
            col_last = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            col_last = COL_W'(r_width - 1'b1);
        end
        if (r_height == '0) begin
            row_last = '0;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            row_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            row_last = ROW_W'(r_height - 1'b1);
        end
    end

    assign eol = (r_col == col_last);
    assign eof = eol && (r_row == row_last);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_addr = r_addr;
        n_hist = r_hist;
        if (i_cfg_we) begin
            n_col  = '0;
            n_row  = '0;
            n_addr = '0;
            n_hist = 1'b0;
        end else if (i_accept) begin
            if (eof) begin
                n_col  = '0;
                n_row  = '0;
                n_addr = '0;
                n_hist = r_enable;
            end else if (eol) begin
                n_col  = '0;
                n_row  = r_row + 1'b1;
                n_addr = r_addr + 1'b1;
            end else begin
                n_col  = r_col + 1'b1;
                n_addr = r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_weight <= 9'd128;
            r_width  <= 11'd640;
            r_height <= 11'd480;
            r_hist   <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_addr   <= '0;
        end else begin
            r_hist <= n_hist;
            r_col  <= n_col;
            r_row  <= n_row;
            r_addr <= n_addr;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_WEIGHT: r_weight <= i_cfg_data[WT_W-1:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                    default:    r_enable <= r_enable;
                endcase
            end
        end
    end

    // Weights above one full step act as a full step.
    assign o_weight = r_weight[WT_W-1] ? WT_FULL : r_weight;

    assign o_item.addr  = r_addr;
    assign o_item.depth = i_depth_mm;
    assign o_item.blend = r_enable && r_hist;
    assign o_item.eof   = eof;

endmodule

### sv/dtef_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtef_store
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dtef_store
    import dtef_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [FILT_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [FILT_W-1:0] o_rdata
);

    logic [FILT_W-1:0] r_mem [STORE_DEPTH];
    logic [FILT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/dtef_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtef_blend
// Blend stage and output register, with forwarding of the write-back value.
// ----------------------------------------------------------------------------
module dtef_blend
    import dtef_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_item             i_item,
    input  logic [WT_W-1:0]   i_weight,
    input  logic [FILT_W-1:0] i_rdata,
    input  logic              i_stall,
    output logic              o_s1_busy,
    output logic              o_s1_adv,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [FILT_W-1:0] o_wdata,
    output logic              o_valid,
    output logic [FILT_W-1:0] o_filtered_depth,
    output logic              o_end_of_frame
);

    t_item             r_s1;
    logic              r_s1_valid;
    logic              r_s1_fwd;
    logic [FILT_W-1:0] r_fwd_data;
    logic              r_out_valid;
    logic [FILT_W-1:0] r_out_data;
    logic              r_out_eof;

    logic [FILT_W-1:0]  prev;
    logic [FILT_W-1:0]  cur;
    logic [DEPTH_W+WT_W-1:0] cur_part;
    logic [FILT_W+WT_W-1:0]  prev_part;
    logic [33:0]        acc;
    logic [FILT_W-1:0]  res;
    logic               s1_adv;

    // The entry read in the same cycle as its write sees the old value, so the
    // write-back value is forwarded instead.
    assign prev      = r_s1_fwd ? r_fwd_data : i_rdata;
    assign cur       = {r_s1.depth, 8'h00};
    assign cur_part  = r_s1.depth * (WT_FULL - i_weight);
    assign prev_part = prev * i_weight;
    assign acc       = {1'b0, cur_part, 8'h00} + 34'(prev_part) + 34'd128;
    assign res       = (r_s1.blend && (prev != '0)) ? acc[31:8] : cur;

    assign s1_adv = r_s1_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1       <= i_item;
            r_s1_fwd   <= s1_adv && (r_s1.addr == i_item.addr);
            r_fwd_data <= res;
        end
        if (s1_adv) begin
            r_out_data <= res;
            r_out_eof  <= r_s1.eof;
        end
    end

    assign o_s1_busy        = r_s1_valid;
    assign o_s1_adv         = s1_adv;
    assign o_we             = s1_adv;
    assign o_waddr          = r_s1.addr;
    assign o_wdata          = res;
    assign o_valid          = r_out_valid;
    assign o_filtered_depth = r_out_data;
    assign o_end_of_frame   = r_out_eof;

endmodule

### sv/depth_temporal_ema_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_temporal_ema_filter_top
// Per-pixel temporal exponential moving average over raster depth frames.
// ----------------------------------------------------------------------------
// The filter takes one depth pixel per clock while the output is not stalled
// and returns one result per pixel, through the blend stage register and
// then the output register. The rate is set by the single frame store read
// and the single write-back that each pixel needs. The store is not cleared
// after reset; history tracking keeps unwritten entries from ever being
// used, so the block is ready in the first cycle after reset. Configuration
// writes restart the frame and drop the history, and belong between frames
// with no pixel in flight.
module depth_temporal_ema_filter_top
    import dtef_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DEPTH_W-1:0]    i_depth_mm,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FILT_W-1:0]     o_filtered_depth,
    output logic                  o_end_of_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_item             item;
    logic [WT_W-1:0]   weight;
    logic              accept;
    logic              s1_busy;
    logic              s1_adv;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [FILT_W-1:0] wdata;
    logic [FILT_W-1:0] rdata;

    assign o_stall = s1_busy && !s1_adv;
    assign accept  = i_valid && !o_stall;

    dtef_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_depth_mm  (i_depth_mm),
        .o_item      (item),
        .o_weight    (weight)
    );

    dtef_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (item.addr),
        .o_rdata (rdata)
    );

    dtef_blend u_blend (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_item           (item),
        .i_weight         (weight),
        .i_rdata          (rdata),
        .i_stall          (i_stall),
        .o_s1_busy        (s1_busy),
        .o_s1_adv         (s1_adv),
        .o_we             (we),
        .o_waddr          (waddr),
        .o_wdata          (wdata),
        .o_valid          (o_valid),
        .o_filtered_depth (o_filtered_depth),
        .o_end_of_frame   (o_end_of_frame)
    );

endmodule

### sv/dtef_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtef_checker
// Port-level checks for the depth temporal EMA filter.
// ----------------------------------------------------------------------------
module dtef_checker
    import dtef_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [DEPTH_W-1:0]    i_depth_mm,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [FILT_W-1:0]     o_filtered_depth,
    input logic                  o_end_of_frame
);

    // A held result stays offered until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_filtered_depth) && $stable(o_end_of_frame))
        else $error("stalled output payload changed");

    // A stalled input pixel stays offered unchanged until its transfer.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_depth_mm))
        else $error("stalled input pixel changed");

    // Input back-pressure only comes from a full output register that is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind depth_temporal_ema_filter_top dtef_checker u_dtef_checker (.*);
